@@ rtl/core/mlp_pkg.sv @@
// Shared types and constants for the metric line parser.
// Holds the character codes, the controller enums, the command and status
// structs and the power-of-ten tables used by the scaling unit.
`timescale 1ns / 1ps

package mlp_pkg;

    localparam int WIDE_W    = 100;
    localparam int CNT_W     = 7;
    localparam int POW_COUNT = 30;
    localparam int POW_IDX_W = 5;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef logic [WIDE_W-1:0] t_wide;
    typedef t_wide [POW_COUNT-1:0] t_pow_tab;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_BAD_VALUE = 2'd2,
        STAT_BAD_STAMP = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_KEY, PH_START, PH_INT, PH_DOT, PH_FRAC,
        PH_EXP, PH_EXPSGN, PH_EXPDIG, PH_STAMP
    } t_phase;

    typedef enum logic [2:0] {
        S_PARSE, S_PREP, S_MUL, S_DIV, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RES_ZERO, RES_SAT, RES_WIDE
    } t_res_sel;

    typedef enum logic [1:0] {
        RK_NONE, RK_OK, RK_FAIL
    } t_res_kind;

    typedef struct packed {
        logic     clear_all;
        logic     key_inc;
        logic     set_neg;
        logic     int_dig;
        logic     frac_dig;
        logic     exp_dig;
        logic     set_exp_sign;
        logic     stamp_dig;
        logic     prep;
        logic     mul_step;
        logic     div_step;
        logic     load_out;
        t_status  out_status;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_space;
        logic is_minus;
        logic is_plus;
        logic is_dot;
        logic is_e;
        logic is_nl;
        logic is_nul;
        logic is_neg;
        logic mant_zero;
        logic mant_sat;
        logic e_pos;
        logic e_neg;
        logic e_over;
        logic k_big;
        logic cnt_zero;
        logic wide_over;
        logic out_free;
    } t_dp_stat;

    function automatic t_pow_tab make_pow_tab();
        t_pow_tab t;
        t[0] = WIDE_W'(1);
        for (int i = 1; i < POW_COUNT; i++) begin
            t[i] = t[i-1] * WIDE_W'(10);
        end
        return t;
    endfunction

    function automatic t_pow_tab make_half_tab();
        t_pow_tab p;
        t_pow_tab t;
        p = make_pow_tab();
        t[0] = '0;
        for (int i = 1; i < POW_COUNT; i++) begin
            t[i] = p[i-1] * WIDE_W'(5);
        end
        return t;
    endfunction

    localparam t_pow_tab POW10_TAB = make_pow_tab();
    localparam t_pow_tab HALF_TAB  = make_half_tab();

endpackage

@@ rtl/core/mlp_ctrl.sv @@
// Controller of the metric line parser: parse phase, line bookkeeping and
// the sequencer that drives the fixed-point scaling. Depends on mlp_pkg.
`timescale 1ns / 1ps

module mlp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_end_of_packet,
    input  mlp_pkg::t_dp_stat i_stat,
    output logic             o_in_stall,
    output mlp_pkg::t_dp_cmd o_cmd
);
    import mlp_pkg::*;

    t_state    r_state, n_state;
    t_phase    r_phase, n_phase;
    logic      r_line_done, n_line_done;
    logic      r_eop_pend, n_eop_pend;
    t_res_sel  r_res_sel, n_res_sel;

    t_phase    p_next;
    t_res_kind p_kind;
    t_status   p_fail;
    t_dp_cmd   p_cmd;
    t_status   eop_stat;
    logic      accept;

    assign o_in_stall = (r_state != S_PARSE) || !i_stat.out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PARSE;
            r_phase     <= PH_KEY;
            r_line_done <= 1'b0;
            r_eop_pend  <= 1'b0;
            r_res_sel   <= RES_ZERO;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_line_done <= n_line_done;
            r_eop_pend  <= n_eop_pend;
            r_res_sel   <= n_res_sel;
        end
    end

    // Byte decode for the current phase.
    always_comb begin
        p_next = r_phase;
        p_kind = RK_NONE;
        p_fail = STAT_BAD_VALUE;
        p_cmd  = '0;
        unique case (r_phase)
            PH_KEY: begin
                if (i_stat.is_space) begin
                    p_next = PH_START;
                end else if (i_stat.is_nul) begin
                    p_kind = RK_FAIL;
                    p_fail = STAT_NO_SPACE;
                end else begin
                    p_cmd.key_inc = 1'b1;
                end
            end
            PH_EXP: begin
                if (i_stat.is_plus || i_stat.is_minus) begin
                    p_cmd.set_exp_sign = 1'b1;
                    p_next = PH_EXPSGN;
                end else if (i_stat.is_digit) begin
                    p_cmd.exp_dig = 1'b1;
                    p_next = PH_EXPDIG;
                end else begin
                    p_kind = RK_FAIL;
                end
            end
            PH_EXPSGN: begin
                if (i_stat.is_digit) begin
                    p_cmd.exp_dig = 1'b1;
                    p_next = PH_EXPDIG;
                end else begin
                    p_kind = RK_FAIL;
                end
            end
            PH_STAMP: begin
                if (i_stat.is_digit) begin
                    p_cmd.stamp_dig = 1'b1;
                end else if (i_stat.is_nl) begin
                    p_kind = RK_OK;
                end else begin
                    p_kind = RK_FAIL;
                    p_fail = STAT_BAD_STAMP;
                end
            end
            default: begin
                priority if (r_phase == PH_START && i_stat.is_minus && !i_stat.is_neg) begin
                    p_cmd.set_neg = 1'b1;
                end else if (i_stat.is_digit && r_phase != PH_DOT && r_phase != PH_FRAC
                             && r_phase != PH_EXPDIG) begin
                    p_cmd.int_dig = 1'b1;
                    p_next = PH_INT;
                end else if (i_stat.is_digit && (r_phase == PH_DOT || r_phase == PH_FRAC)) begin
                    p_cmd.frac_dig = 1'b1;
                    p_next = PH_FRAC;
                end else if (i_stat.is_digit) begin
                    p_cmd.exp_dig = 1'b1;
                end else if (i_stat.is_dot && r_phase == PH_START) begin
                    p_next = PH_DOT;
                end else if (i_stat.is_dot && r_phase == PH_INT) begin
                    p_next = PH_FRAC;
                end else if (i_stat.is_e && (r_phase == PH_INT || r_phase == PH_FRAC)) begin
                    p_next = PH_EXP;
                end else if (i_stat.is_nl) begin
                    p_kind = RK_OK;
                end else if (i_stat.is_space) begin
                    p_next = PH_STAMP;
                end else begin
                    p_kind = RK_FAIL;
                end
            end
        endcase
    end

    always_comb begin
        unique case (p_next)
            PH_KEY:   eop_stat = STAT_NO_SPACE;
            PH_STAMP: eop_stat = STAT_BAD_STAMP;
            default:  eop_stat = STAT_BAD_VALUE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_line_done = r_line_done;
        n_eop_pend  = r_eop_pend;
        n_res_sel   = r_res_sel;
        o_cmd       = '0;
        unique case (r_state)
            S_PARSE: begin
                if (accept) begin
                    if (r_line_done) begin
                        if (i_end_of_packet) begin
                            o_cmd.clear_all = 1'b1;
                            n_phase     = PH_KEY;
                            n_line_done = 1'b0;
                        end
                    end else begin
                        unique case (p_kind)
                            RK_OK: begin
                                n_state    = S_PREP;
                                n_eop_pend = i_end_of_packet;
                            end
                            RK_FAIL: begin
                                o_cmd.load_out   = 1'b1;
                                o_cmd.out_status = p_fail;
                                if (i_end_of_packet) begin
                                    o_cmd.clear_all = 1'b1;
                                    n_phase = PH_KEY;
                                end else begin
                                    n_line_done = 1'b1;
                                end
                            end
                            default: begin
                                if (i_end_of_packet) begin
                                    o_cmd.load_out   = 1'b1;
                                    o_cmd.out_status = eop_stat;
                                    o_cmd.clear_all  = 1'b1;
                                    n_phase = PH_KEY;
                                end else begin
                                    o_cmd   = p_cmd;
                                    n_phase = p_next;
                                end
                            end
                        endcase
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_res_sel  = RES_WIDE;
                n_state    = S_EMIT;
                priority if (i_stat.mant_zero) begin
                    n_res_sel = RES_ZERO;
                end else if (i_stat.mant_sat || i_stat.e_over) begin
                    n_res_sel = RES_SAT;
                end else if (i_stat.e_pos) begin
                    n_state = S_MUL;
                end else if (i_stat.e_neg && i_stat.k_big) begin
                    n_res_sel = RES_ZERO;
                end else if (i_stat.e_neg) begin
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                priority if (i_stat.cnt_zero) begin
                    n_state = S_EMIT;
                end else if (i_stat.wide_over) begin
                    n_res_sel = RES_SAT;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            default: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = STAT_OK;
                    o_cmd.res_sel    = r_res_sel;
                    n_state          = S_PARSE;
                    if (r_eop_pend) begin
                        o_cmd.clear_all = 1'b1;
                        n_phase     = PH_KEY;
                        n_line_done = 1'b0;
                    end else begin
                        n_line_done = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

@@ rtl/core/mlp_dpath.sv @@
// Datapath of the metric line parser: key count, value and timestamp
// accumulators, the shift-add scaling unit and the result register.
// Depends on mlp_pkg.
`timescale 1ns / 1ps

module mlp_dpath #(
    parameter int MAX_LEN   = 512,
    parameter int FRAC_BITS = 16,
    parameter int MAX_EXP   = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_byte,
    input  mlp_pkg::t_dp_cmd  i_cmd,
    input  logic              i_out_stall,
    output mlp_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    output logic [1:0]        o_status,
    output logic [8:0]        o_key_len,
    output logic signed [63:0] o_value,
    output logic [31:0]       o_timestamp
);
    import mlp_pkg::*;

    localparam int KEY_CAP = ((MAX_LEN - 1) < 511) ? (MAX_LEN - 1) : 511;
    localparam logic [67:0] MANT_MAX = 68'h0_FFFF_FFFF_FFFF_FFFF;
    localparam logic [35:0] STAMP_MAX = 36'h0_FFFF_FFFF;

    logic [8:0]          r_key_count;
    logic                r_neg;
    logic [63:0]         r_mant;
    logic [4:0]          r_frac_cnt;
    logic [5:0]          r_exp;
    logic                r_exp_neg;
    logic [31:0]         r_stamp;
    t_wide               r_wide;
    logic [WIDE_W:0]     r_rem;
    t_wide               r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [8:0]          r_key_len;
    logic [63:0]         r_value;
    logic [31:0]         r_timestamp;

    logic [3:0]          digit;
    logic [67:0]         mant_x10;
    logic [9:0]          exp_x10;
    logic [35:0]         stamp_x10;
    logic signed [7:0]   exp_s;
    logic signed [7:0]   e_val;
    logic [7:0]          k_mag;
    logic [POW_IDX_W-1:0] k_idx;
    t_wide               x_val;
    t_wide               wide_x10;
    logic [WIDE_W:0]     rem_sh;
    logic                rem_ge;
    logic [63:0]         sat_val;
    logic [63:0]         wide_val;
    logic [63:0]         ok_val;
    logic                out_free;

    assign digit     = i_data_byte[3:0];
    assign mant_x10  = ({4'b0, r_mant} << 3) + ({4'b0, r_mant} << 1) + 68'(digit);
    assign exp_x10   = ({4'b0, r_exp} << 3) + ({4'b0, r_exp} << 1) + 10'(digit);
    assign stamp_x10 = ({4'b0, r_stamp} << 3) + ({4'b0, r_stamp} << 1) + 36'(digit);

    assign exp_s = r_exp_neg ? -$signed({2'b0, r_exp}) : $signed({2'b0, r_exp});
    assign e_val = exp_s - $signed({3'b0, r_frac_cnt});
    assign k_mag = 8'(-e_val);
    assign k_idx = (k_mag >= 8'(POW_COUNT)) ? '0 : k_mag[POW_IDX_W-1:0];

    assign x_val    = t_wide'(r_mant) << FRAC_BITS;
    assign wide_x10 = (r_wide << 3) + (r_wide << 1);
    assign rem_sh   = {r_rem[WIDE_W-1:0], r_wide[WIDE_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_div};

    assign sat_val  = r_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    assign wide_val = r_neg ? (64'd0 - r_wide[63:0]) : r_wide[63:0];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.is_digit  = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
        o_stat.is_space  = i_data_byte == CH_SPACE;
        o_stat.is_minus  = i_data_byte == CH_MINUS;
        o_stat.is_plus   = i_data_byte == CH_PLUS;
        o_stat.is_dot    = i_data_byte == CH_DOT;
        o_stat.is_e      = i_data_byte == CH_E;
        o_stat.is_nl     = i_data_byte == CH_NL;
        o_stat.is_nul    = i_data_byte == CH_NUL;
        o_stat.is_neg    = r_neg;
        o_stat.mant_zero = r_mant == '0;
        o_stat.mant_sat  = r_mant == '1;
        o_stat.e_pos     = e_val > 8'sd0;
        o_stat.e_neg     = e_val < 8'sd0;
        o_stat.e_over    = e_val > $signed(8'(MAX_EXP));
        o_stat.k_big     = k_mag >= 8'(POW_COUNT);
        o_stat.cnt_zero  = r_cnt == '0;
        o_stat.wide_over = (|r_wide[WIDE_W-1:64])
                           || (r_wide[63] && ((|r_wide[62:0]) || !r_neg));
        o_stat.out_free  = out_free;
    end

    always_comb begin
        unique case (i_cmd.res_sel)
            RES_ZERO: ok_val = '0;
            RES_SAT:  ok_val = sat_val;
            default:  ok_val = o_stat.wide_over ? sat_val : wide_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_key_count <= '0;
            r_neg       <= 1'b0;
            r_mant      <= '0;
            r_frac_cnt  <= '0;
            r_exp       <= '0;
            r_exp_neg   <= 1'b0;
            r_stamp     <= '0;
        end else begin
            if (i_cmd.key_inc && (r_key_count < 9'(KEY_CAP))) begin
                r_key_count <= r_key_count + 9'd1;
            end
            if (i_cmd.set_neg) begin
                r_neg <= 1'b1;
            end
            if (i_cmd.int_dig) begin
                r_mant <= (mant_x10 >= MANT_MAX) ? '1 : mant_x10[63:0];
            end
            if (i_cmd.frac_dig && (r_frac_cnt < 5'd31) && (mant_x10 < MANT_MAX)) begin
                r_mant     <= mant_x10[63:0];
                r_frac_cnt <= r_frac_cnt + 5'd1;
            end
            if (i_cmd.set_exp_sign) begin
                r_exp_neg <= o_stat.is_minus;
            end
            if (i_cmd.exp_dig) begin
                r_exp <= (exp_x10 > 10'd63) ? 6'd63 : exp_x10[5:0];
            end
            if (i_cmd.stamp_dig) begin
                r_stamp <= (stamp_x10 > STAMP_MAX) ? '1 : stamp_x10[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_wide <= (o_stat.e_neg && !o_stat.k_big) ? (x_val + HALF_TAB[k_idx]) : x_val;
            r_div  <= POW10_TAB[k_idx];
            r_rem  <= '0;
            r_cnt  <= o_stat.e_pos ? e_val[CNT_W-1:0] : CNT_W'(WIDE_W);
        end else if (i_cmd.mul_step) begin
            r_wide <= wide_x10;
            r_cnt  <= r_cnt - 1'b1;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
            r_wide <= {r_wide[WIDE_W-2:0], rem_ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status    <= i_cmd.out_status;
            r_key_len   <= (i_cmd.out_status == STAT_NO_SPACE) ? '0 : r_key_count;
            r_value     <= (i_cmd.out_status == STAT_OK) ? ok_val : '0;
            r_timestamp <= (i_cmd.out_status == STAT_OK) ? r_stamp : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_key_len   = r_key_len;
    assign o_value     = r_value;
    assign o_timestamp = r_timestamp;

endmodule

@@ rtl/core/metric_line_parser_unit.sv @@
// An error result is valid the cycle after its byte; a good line passes
// through the prep state, one multiply by ten per power of ten up or a
// rounding division by a power of ten in the shift-add scaling unit, then emit.
// Throughput: one byte per cycle while parsing, unless a held result is stalled; input stalls while scaling.
// Reset: synchronous, active low; parser returns to the key phase, no result.
`timescale 1ns / 1ps

module metric_line_parser_unit #(
    parameter int MAX_LEN   = 512,
    parameter int FRAC_BITS = 16,
    parameter int MAX_EXP   = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_packet,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [8:0]         o_key_len,
    output logic signed [63:0] o_value,
    output logic [31:0]        o_timestamp
);
    import mlp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mlp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_end_of_packet (i_end_of_packet),
        .i_stat          (stat),
        .o_in_stall      (o_in_stall),
        .o_cmd           (cmd)
    );

    mlp_dpath #(
        .MAX_LEN   (MAX_LEN),
        .FRAC_BITS (FRAC_BITS),
        .MAX_EXP   (MAX_EXP)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_data_byte),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_key_len   (o_key_len),
        .o_value     (o_value),
        .o_timestamp (o_timestamp)
    );

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STAT_OK) |-> (o_value == '0) && (o_timestamp == '0))
        else $error("failed beat carries a value or timestamp");

    a_no_space_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_NO_SPACE) |-> (o_key_len == '0))
        else $error("missing-space beat reports a key length");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded over a beat not yet taken");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for metric_line_parser_unit: drives packet beats with random gaps
// and checks each result beat against an in-bench line parser and fixed-point scaler.
// Depends on mlp_pkg and the metric_line_parser_unit RTL.
`timescale 1ns / 1ps

module tb_top;
    import mlp_pkg::*;

    localparam int MAX_LEN   = 512;
    localparam int FRAC_BITS = 16;
    localparam int MAX_EXP   = 18;
    localparam int KEY_CAP   = (MAX_LEN - 1 < 511) ? MAX_LEN - 1 : 511;
    localparam logic [63:0] MANT_FULL = '1;

    typedef struct {
        t_status     status;
        logic [8:0]  key_len;
        logic [63:0] value;
        logic [31:0] stamp;
    } t_line_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_end_of_packet = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [8:0]  o_key_len;
    logic signed [63:0] o_value;
    logic [31:0] o_timestamp;

    logic [8:0]  beat_q[$];
    t_line_res   line_res_q[$];
    bit          beat_taken = 1'b0;
    int          taken_cnt = 0;
    int          err_cnt = 0;
    int          cyc_cnt = 0;

    t_phase      ph;
    logic [8:0]  key_cnt;
    bit          neg;
    logic [63:0] mant;
    logic [4:0]  frac_cnt;
    logic [5:0]  exp_acc;
    bit          exp_neg;
    logic [31:0] stamp_acc;
    bit          line_done;

    metric_line_parser_unit #(
        .MAX_LEN(MAX_LEN), .FRAC_BITS(FRAC_BITS), .MAX_EXP(MAX_EXP)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_data_byte(i_data_byte), .i_end_of_packet(i_end_of_packet),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_key_len(o_key_len),
        .o_value(o_value), .o_timestamp(o_timestamp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void clear_line();
        ph = PH_KEY;
        key_cnt = '0;
        neg = 1'b0;
        mant = '0;
        frac_cnt = '0;
        exp_acc = '0;
        exp_neg = 1'b0;
        stamp_acc = '0;
        line_done = 1'b0;
    endfunction

    function automatic logic [63:0] sat_value(bit n);
        return n ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    function automatic bit too_wide(logic [127:0] l, bit n);
        if (l[127:64] != 0 || l[63:0] > 64'h8000_0000_0000_0000) return 1'b1;
        return l[63:0] == 64'h8000_0000_0000_0000 && !n;
    endfunction

    function automatic logic [63:0] scaled_value();
        logic [127:0] l;
        logic [127:0] rem;
        int e;
        if (mant == 0) return '0;
        if (mant == MANT_FULL) return sat_value(neg);
        l = {64'b0, mant} << FRAC_BITS;
        e = (exp_neg ? -int'(exp_acc) : int'(exp_acc)) - int'(frac_cnt);
        if (e > 0) begin
            if (e > MAX_EXP) return sat_value(neg);
            for (int i = 0; i < e; i++) begin
                if (too_wide(l, neg)) return sat_value(neg);
                l = l * 10;
            end
        end else if (e < 0) begin
            for (int i = 0; i < -e - 1; i++) l = l / 10;
            rem = l % 10;
            l = l / 10;
            if (rem >= 5) l = l + 1;
        end
        if (too_wide(l, neg)) return sat_value(neg);
        return neg ? -l[63:0] : l[63:0];
    endfunction

    function automatic bit line_ok(output t_line_res r);
        r.status = STAT_OK;
        r.key_len = key_cnt;
        r.value = scaled_value();
        r.stamp = stamp_acc;
        line_done = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit line_fail(t_status s, output t_line_res r);
        r.status = s;
        r.key_len = (s == STAT_NO_SPACE) ? 9'd0 : key_cnt;
        r.value = '0;
        r.stamp = '0;
        line_done = 1'b1;
        return 1'b1;
    endfunction

    function automatic void add_int_digit(int d);
        logic [127:0] v;
        v = {64'b0, mant} * 10 + d;
        mant = (v >= {64'b0, MANT_FULL}) ? MANT_FULL : v[63:0];
    endfunction

    function automatic void add_frac_digit(int d);
        logic [127:0] v;
        v = {64'b0, mant} * 10 + d;
        if (frac_cnt >= 31 || v >= {64'b0, MANT_FULL}) return;
        mant = v[63:0];
        frac_cnt++;
    endfunction

    function automatic void add_exp_digit(int d);
        int v;
        v = exp_acc * 10 + d;
        exp_acc = (v > 63) ? 6'd63 : v[5:0];
    endfunction

    function automatic bit value_end(logic [7:0] c, output t_line_res r);
        if (c == CH_NL) return line_ok(r);
        if (c == CH_SPACE) begin
            ph = PH_STAMP;
            return 1'b0;
        end
        return line_fail(STAT_BAD_VALUE, r);
    endfunction

    function automatic bit parse_char(logic [7:0] c, output t_line_res r);
        bit dig;
        int d;
        logic [35:0] sv;
        dig = c >= CH_ZERO && c <= CH_NINE;
        d = c - CH_ZERO;
        r = '{STAT_OK, '0, '0, '0};
        case (ph)
            PH_KEY: begin
                if (c == CH_SPACE) begin
                    ph = PH_START;
                    return 1'b0;
                end
                if (c == CH_NUL) return line_fail(STAT_NO_SPACE, r);
                if (key_cnt < KEY_CAP) key_cnt++;
                return 1'b0;
            end
            PH_START: begin
                if (c == CH_MINUS && !neg) begin
                    neg = 1'b1;
                    return 1'b0;
                end
                if (dig) begin
                    add_int_digit(d);
                    ph = PH_INT;
                    return 1'b0;
                end
                if (c == CH_DOT) begin
                    ph = PH_DOT;
                    return 1'b0;
                end
                return value_end(c, r);
            end
            PH_INT: begin
                if (dig) begin
                    add_int_digit(d);
                    return 1'b0;
                end
                if (c == CH_DOT) begin
                    ph = PH_FRAC;
                    return 1'b0;
                end
                if (c == CH_E) begin
                    ph = PH_EXP;
                    return 1'b0;
                end
                return value_end(c, r);
            end
            PH_DOT: begin
                if (dig) begin
                    add_frac_digit(d);
                    ph = PH_FRAC;
                    return 1'b0;
                end
                return value_end(c, r);
            end
            PH_FRAC: begin
                if (dig) begin
                    add_frac_digit(d);
                    return 1'b0;
                end
                if (c == CH_E) begin
                    ph = PH_EXP;
                    return 1'b0;
                end
                return value_end(c, r);
            end
            PH_EXP: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    exp_neg = (c == CH_MINUS);
                    ph = PH_EXPSGN;
                    return 1'b0;
                end
                if (dig) begin
                    add_exp_digit(d);
                    ph = PH_EXPDIG;
                    return 1'b0;
                end
                return line_fail(STAT_BAD_VALUE, r);
            end
            PH_EXPSGN: begin
                if (dig) begin
                    add_exp_digit(d);
                    ph = PH_EXPDIG;
                    return 1'b0;
                end
                return line_fail(STAT_BAD_VALUE, r);
            end
            PH_EXPDIG: begin
                if (dig) begin
                    add_exp_digit(d);
                    return 1'b0;
                end
                return value_end(c, r);
            end
            default: begin
                if (dig) begin
                    sv = {4'b0, stamp_acc} * 10 + d;
                    stamp_acc = (sv > 36'hF_FFFF_FFFF >> 4) ? 32'hFFFF_FFFF : sv[31:0];
                    return 1'b0;
                end
                if (c == CH_NL) return line_ok(r);
                return line_fail(STAT_BAD_STAMP, r);
            end
        endcase
    endfunction

    function automatic void take_beat(logic [7:0] c, bit eop);
        t_line_res r;
        bit got;
        got = 1'b0;
        if (!line_done) begin
            got = parse_char(c, r);
            if (!got && eop) got = parse_char(CH_NUL, r);
        end
        if (got) line_res_q.push_back(r);
        if (eop) clear_line();
    endfunction

    always @(posedge i_clk) begin
        beat_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (beat_taken) begin
            take_beat(i_data_byte, i_end_of_packet);
            taken_cnt++;
        end
    end

    always @(posedge i_clk) begin
        t_line_res r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (line_res_q.size() == 0) begin
                $error("unexpected result beat: status %0d", o_status);
                err_cnt++;
            end else begin
                r = line_res_q.pop_front();
                if (o_status !== r.status) begin
                    $error("status: expected %0d, got %0d", r.status, o_status);
                    err_cnt++;
                end
                if (o_key_len !== r.key_len) begin
                    $error("key_len: expected %0d, got %0d", r.key_len, o_key_len);
                    err_cnt++;
                end
                if (o_value !== r.value) begin
                    $error("value: expected %0d, got %0d", $signed(r.value), o_value);
                    err_cnt++;
                end
                if (o_timestamp !== r.stamp) begin
                    $error("timestamp: expected %0d, got %0d", r.stamp, o_timestamp);
                    err_cnt++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        bit calm;
        calm = taken_cnt >= 300 && taken_cnt < 500;
        if (i_rst_n) begin
            if (!i_in_valid || beat_taken) begin
                if (beat_q.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
                    {i_end_of_packet, i_data_byte} <= beat_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !calm && $urandom_range(99) < 27;
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > 1000000) begin
            $display("metric_line_parser_unit: mismatch");
            $finish;
        end
    end

    function automatic void push_text(string s, bit eop_last);
        for (int i = 0; i < s.len(); i++)
            beat_q.push_back({eop_last && i == s.len() - 1, s[i]});
    endfunction

    function automatic string digit_run(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'(CH_ZERO + $urandom_range(9)))};
        return s;
    endfunction

    function automatic void push_random_line();
        string s;
        byte b;
        int pos;
        s = "";
        for (int i = $urandom_range(6); i > 0; i--)
            s = {s, string'(byte'($urandom_range(33, 126)))};
        s = {s, " "};
        if ($urandom_range(3) == 0) s = {s, "-"};
        s = {s, digit_run($urandom_range(3) == 0 ? $urandom_range(22) : $urandom_range(5))};
        if ($urandom_range(1)) s = {s, ".", digit_run($urandom_range(3) == 0 ? 35 : 4)};
        if ($urandom_range(3) == 0) begin
            s = {s, "e"};
            case ($urandom_range(2))
                0: s = {s, "+"};
                1: s = {s, "-"};
                default: ;
            endcase
            s = {s, digit_run($urandom_range(1, 2))};
        end
        if ($urandom_range(1)) s = {s, " ", digit_run($urandom_range(1, 12))};
        if ($urandom_range(7) != 0) s = {s, "\n"};
        if ($urandom_range(4) == 0) begin
            b = $urandom_range(255);
            pos = $urandom_range(s.len() - 1);
            s = {s.substr(0, pos - 1), string'(b), s.substr(pos, s.len() - 1)};
        end
        for (int i = $urandom_range(2); i > 0; i--)
            s = {s, string'(byte'($urandom_range(1, 255)))};
        if (s.len() == 0) s = "x";
        push_text(s, 1'b1);
    endfunction

    initial begin
        string long_key;
        int n;
        clear_line();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_text("k 1\n", 1);
        push_text("abc -12.5e3 1700000000\n", 1);
        push_text(" 0\n", 1);
        push_text("key \n", 1);
        push_text("key -\n", 1);
        push_text("key .\n", 1);
        push_text("k --1\n", 1);
        push_text("k e5\n", 1);
        push_text("k 1e\n", 1);
        push_text("k 1e+\n", 1);
        push_text("k 1.5e-3\n", 1);
        push_text("k 2.5e-16\n", 1);
        push_text("k 18446744073709551615\n", 1);
        push_text("k -140737488355328\n", 1);
        push_text("k 1e19\n", 1);
        push_text("k 1e99\n", 1);
        push_text("k 0.00000001\n", 1);
        push_text("k 1 99999999999\n", 1);
        push_text("k 1 12x\n", 1);
        push_text("k 1x\n", 1);
        push_text("k 7", 1);
        push_text("k 1\nXYZ", 1);
        beat_q.push_back({1'b0, 8'h6B});
        beat_q.push_back({1'b0, CH_NUL});
        beat_q.push_back({1'b1, 8'hFF});
        long_key = "";
        for (int i = 0; i < 520; i++) long_key = {long_key, "a"};
        push_text({long_key, " 3\n"}, 1);

        while (beat_q.size() > 0 || i_in_valid || line_res_q.size() > 0) @(posedge i_clk);

        n = 0;
        while (n < 1000) begin
            if ($urandom_range(9) == 0) begin
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    beat_q.push_back({i == 1, 8'($urandom_range(255))});
            end else begin
                push_random_line();
            end
            n = beat_q.size() + taken_cnt;
        end

        while (beat_q.size() > 0 || i_in_valid || line_res_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0 && line_res_q.size() == 0) begin
            $display("metric_line_parser_unit: match");
        end else begin
            $display("metric_line_parser_unit: mismatch");
        end
        $finish;
    end

endmodule
